>>> rtl/mpds_pkg.sv
package mpds_pkg;

   localparam int MAX_FRAME_DIM       = 8192;
   localparam int PREVIEW_WIDTH_LIMIT = 1280;

   localparam int DIM_W     = 14;   // frame dimensions, 1..8192
   localparam int POS_W     = 13;   // source raster position
   localparam int PCOL_W    = 11;   // preview column / preview width
   localparam int PROW_W    = 14;   // preview row counter and height
   localparam int SAMPLE_W  = 16;
   localparam int PIX_W     = 8;
   localparam int DIV_NUM_W = 28;
   localparam int DIV_DEN_W = 16;
   localparam int DIV_CNT_W = 5;
   localparam int ADDR_W    = 4;
   localparam int DATA_W    = 32;

   localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
   localparam logic [1:0] REG_WIDE_SAMPLES   = 2'd2;
   localparam logic [1:0] REG_STRETCH_ENABLE = 2'd3;

   localparam logic [SAMPLE_W-1:0] MIN_RESET = 16'hFFFF;
   localparam logic [PIX_W-1:0]    PIX_FULL  = 8'd255;

   typedef struct packed {
      logic [DIM_W-1:0] frame_width;
      logic [DIM_W-1:0] frame_height;
      logic             wide_samples;
      logic             stretch_enable;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_PH_WAIT,
      ST_CHECK,
      ST_PIX_WAIT,
      ST_EMIT,
      ST_NXT_WAIT
   } state_type;

   typedef enum logic [1:0] {
      OP_PH,
      OP_PIX,
      OP_NXT
   } div_op_type;

   typedef struct packed {
      logic       latch_item;
      logic       stats_update;
      logic       ph_load;
      logic       pix_direct;
      logic       pix_load;
      logic       emit;
      logic       nxt_load;
      logic       advance;
      logic       div_start;
      div_op_type div_op;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_render;
      logic at_start;
      logic emit_ok;
      logic pix_needs_div;
      logic div_done;
      logic out_free;
   } dp_status_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] r;
      r = d;
      if (d == '0) begin
         r = DIM_W'(1);
      end else if (d > DIM_W'(MAX_FRAME_DIM)) begin
         r = DIM_W'(MAX_FRAME_DIM);
      end
      return r;
   endfunction

endpackage

>>> rtl/mono_preview_downscale_stretch_top.sv
// Channel   | Direction | Fields
// req_      | in        | tdata[15:0] sample_value, tuser[0] command
// rsp_      | out       | tdata pixel/column/row, tuser row_end, tlast frame_end
// csr_      | APB       | 0 frame_width, 4 frame_height, 8 wide_samples, 12 stretch_enable
//
// One transaction at a time. A statistics sample and a skipped render sample
// need no division; a kept one uses the shared restoring divider for the next
// sample position, once more when the stretch needs a true division, and once
// more at the start of a render pass.
// Synchronous active-high reset; no clearing pass.
// A stalled result holds in the output register; the block then waits in the
// emit step before loading the next one.
module mono_preview_downscale_stretch_top
   import mpds_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [15:0]       req_tdata,   // [15:0] sample_value
   input  logic [0:0]        req_tuser,   // [0] command
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,   // [7:0] preview_pixel, [18:8] preview_column,
                                          // [31:19] preview_row
   output logic [0:0]        rsp_tuser,   // [0] row_end
   output logic              rsp_tlast,   // frame_end
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   cfg_type       cfg_ff;
   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          csr_wr;
   logic [1:0]    csr_idx;
   logic [PIX_W-1:0]  pixel;
   logic [PCOL_W-1:0] column;
   logic [POS_W-1:0]  row;
   logic              row_end, frame_end;

   // register file: written on the APB access phase
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width    <= DIM_W'(1280);
         cfg_ff.frame_height   <= DIM_W'(960);
         cfg_ff.wide_samples   <= 1'b1;
         cfg_ff.stretch_enable <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_FRAME_WIDTH:    cfg_ff.frame_width    <= csr_pwdata[DIM_W-1:0];
            REG_FRAME_HEIGHT:   cfg_ff.frame_height   <= csr_pwdata[DIM_W-1:0];
            REG_WIDE_SAMPLES:   cfg_ff.wide_samples   <= csr_pwdata[0];
            REG_STRETCH_ENABLE: cfg_ff.stretch_enable <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_FRAME_WIDTH:    csr_prdata = DATA_W'(cfg_ff.frame_width);
         REG_FRAME_HEIGHT:   csr_prdata = DATA_W'(cfg_ff.frame_height);
         REG_WIDE_SAMPLES:   csr_prdata = DATA_W'(cfg_ff.wide_samples);
         REG_STRETCH_ENABLE: csr_prdata = DATA_W'(cfg_ff.stretch_enable);
         default:            csr_prdata = '0;
      endcase
   end

   // sequencer
   mpds_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // statistics, position tracking, mapping and output register
   mpds_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .cmd           (cmd),
      .status        (status),
      .req_command   (req_tuser[0]),
      .req_sample    (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_pixel     (pixel),
      .rsp_column    (column),
      .rsp_row       (row),
      .rsp_row_end   (row_end),
      .rsp_frame_end (frame_end)
   );

   assign rsp_tdata = {row, column, pixel};
   assign rsp_tuser = row_end;
   assign rsp_tlast = frame_end;

endmodule

>>> rtl/mpds_div.sv
module mpds_div
   import mpds_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output logic                 done,
   output logic [DIV_NUM_W-1:0] quot
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_DEN_W:0]   rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quot_ff, quot_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   rem_shift;
   logic                 ge;

   // one quotient bit per cycle, restoring
   always_comb begin
      rem_shift = {rem_ff[DIV_DEN_W-1:0], quot_ff[DIV_NUM_W-1]};
      ge        = rem_shift >= {1'b0, den_ff};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quot_in   = quot_ff;
      den_in    = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quot_in = num;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in  = ge ? (rem_shift - {1'b0, den_ff}) : rem_shift;
         quot_in = {quot_ff[DIV_NUM_W-2:0], ge};
         cnt_in  = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

>>> rtl/mpds_ctrl.sv
module mpds_ctrl
   import mpds_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (!status.is_render) state_in = ST_IDLE;
            else if (status.at_start) state_in = ST_PH_WAIT;
            else state_in = ST_CHECK;
         end
         ST_PH_WAIT: begin
            if (status.div_done) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!status.emit_ok) state_in = ST_IDLE;
            else if (status.pix_needs_div) state_in = ST_PIX_WAIT;
            else state_in = ST_EMIT;
         end
         ST_PIX_WAIT: begin
            if (status.div_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) state_in = ST_NXT_WAIT;
         end
         ST_NXT_WAIT: begin
            if (status.div_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.div_op = OP_PH;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready     = 1'b1;
            cmd.latch_item = req_tvalid;
         end
         ST_DECODE: begin
            if (!status.is_render) begin
               cmd.stats_update = 1'b1;
               cmd.advance      = 1'b1;
            end else if (status.at_start) begin
               cmd.div_start = 1'b1;
               cmd.div_op    = OP_PH;
            end
         end
         ST_PH_WAIT: begin
            cmd.ph_load = status.div_done;
         end
         ST_CHECK: begin
            if (!status.emit_ok) begin
               cmd.advance = 1'b1;
            end else if (status.pix_needs_div) begin
               cmd.div_start = 1'b1;
               cmd.div_op    = OP_PIX;
            end else begin
               cmd.pix_direct = 1'b1;
            end
         end
         ST_PIX_WAIT: begin
            cmd.pix_load = status.div_done;
         end
         ST_EMIT: begin
            cmd.emit      = status.out_free;
            cmd.div_start = status.out_free;
            cmd.div_op    = OP_NXT;
         end
         ST_NXT_WAIT: begin
            cmd.nxt_load = status.div_done;
            cmd.advance  = status.div_done;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

>>> rtl/mpds_dp.sv
module mpds_dp
   import mpds_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         status,
   input  logic                  req_command,
   input  logic [SAMPLE_W-1:0]   req_sample,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [PIX_W-1:0]      rsp_pixel,
   output logic [PCOL_W-1:0]     rsp_column,
   output logic [POS_W-1:0]      rsp_row,
   output logic                  rsp_row_end,
   output logic                  rsp_frame_end
);

   logic                  cmd_ff;
   logic [SAMPLE_W-1:0]   v_ff;
   logic [SAMPLE_W-1:0]   min_ff, max_ff, min_in, max_in;
   logic                  stretch_ff;
   logic [POS_W-1:0]      src_col_ff, src_row_ff;
   logic [PCOL_W-1:0]     col_cnt_ff;
   logic [PROW_W-1:0]     row_cnt_ff;
   logic [POS_W-1:0]      nxt_col_ff;
   logic [PROW_W-1:0]     nxt_row_ff;
   logic [PROW_W-1:0]     ph_ff;
   logic [PIX_W-1:0]      pix_ff;
   logic                  nxt_is_row_ff;
   logic                  out_valid_ff;
   logic [PIX_W-1:0]      out_pix_ff;
   logic [PCOL_W-1:0]     out_col_ff;
   logic [POS_W-1:0]      out_row_ff;
   logic                  out_row_end_ff, out_frame_end_ff;

   logic [DIM_W-1:0]      w, h;
   logic [PCOL_W-1:0]     pw;
   logic                  at_start, row_end_now, frame_end_now, out_free;
   logic [PIX_W-1:0]      pix_direct;
   logic [DIV_NUM_W-1:0]  div_num, div_quot;
   logic [DIV_DEN_W-1:0]  div_den;
   logic                  div_done;

   assign w  = clamp_dim(cfg.frame_width);
   assign h  = clamp_dim(cfg.frame_height);
   assign pw = (w < DIM_W'(PREVIEW_WIDTH_LIMIT)) ? w[PCOL_W-1:0]
                                                  : PCOL_W'(PREVIEW_WIDTH_LIMIT);

   assign at_start      = (src_col_ff == '0) && (src_row_ff == '0);
   assign row_end_now   = (12'(col_cnt_ff) + 12'd1) >= 12'(pw);
   assign frame_end_now = row_end_now && ((15'(row_cnt_ff) + 15'd1) >= 15'(ph_ff));
   assign out_free      = !out_valid_ff || rsp_tready;

   always_comb begin
      if (stretch_ff) pix_direct = (v_ff <= min_ff) ? '0 : PIX_FULL;
      else if (cfg.wide_samples) pix_direct = v_ff[SAMPLE_W-1:PIX_W];
      else pix_direct = v_ff[PIX_W-1:0];
   end

   assign status.is_render     = cmd_ff;
   assign status.at_start      = at_start;
   assign status.emit_ok       = (row_cnt_ff < ph_ff) && (src_col_ff == nxt_col_ff)
                                 && ({1'b0, src_row_ff} == nxt_row_ff);
   assign status.pix_needs_div = stretch_ff && (v_ff > min_ff) && (v_ff < max_ff);
   assign status.div_done      = div_done;
   assign status.out_free      = out_free;

   always_comb begin
      unique case (cmd.div_op)
         OP_PH: begin
            div_num = DIV_NUM_W'(h) * DIV_NUM_W'(pw);
            div_den = DIV_DEN_W'(w);
         end
         OP_PIX: begin
            div_num = DIV_NUM_W'(v_ff - min_ff) * DIV_NUM_W'(PIX_FULL);
            div_den = max_ff - min_ff;
         end
         OP_NXT: begin
            if (row_end_now) begin
               div_num = (DIV_NUM_W'(row_cnt_ff) + DIV_NUM_W'(1)) * DIV_NUM_W'(h);
               div_den = DIV_DEN_W'(ph_ff);
            end else begin
               div_num = (DIV_NUM_W'(col_cnt_ff) + DIV_NUM_W'(1)) * DIV_NUM_W'(w);
               div_den = DIV_DEN_W'(pw);
            end
         end
         default: begin
            div_num = '0;
            div_den = DIV_DEN_W'(1);
         end
      endcase
   end

   mpds_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      min_in = at_start ? MIN_RESET : min_ff;
      max_in = at_start ? '0 : max_ff;
      if (v_ff < min_in) min_in = v_ff;
      if (v_ff > max_in) max_in = v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff        <= MIN_RESET;
         max_ff        <= '0;
         stretch_ff    <= 1'b0;
         src_col_ff    <= '0;
         src_row_ff    <= '0;
         col_cnt_ff    <= '0;
         row_cnt_ff    <= '0;
         nxt_col_ff    <= '0;
         nxt_row_ff    <= '0;
         ph_ff         <= PROW_W'(960);
         out_valid_ff  <= 1'b0;
         cmd_ff        <= 1'b0;
      end else begin
         if (cmd.latch_item) cmd_ff <= req_command;
         if (cmd.stats_update) begin
            min_ff <= min_in;
            max_ff <= max_in;
         end
         if (cmd.ph_load) begin
            ph_ff      <= (div_quot == '0) ? PROW_W'(1) : div_quot[PROW_W-1:0];
            col_cnt_ff <= '0;
            row_cnt_ff <= '0;
            nxt_col_ff <= '0;
            nxt_row_ff <= '0;
            stretch_ff <= cfg.stretch_enable && (max_ff > min_ff);
         end
         if (cmd.emit) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
         if (cmd.emit) begin
            if (row_end_now) begin
               col_cnt_ff <= '0;
               row_cnt_ff <= row_cnt_ff + PROW_W'(1);
               nxt_col_ff <= '0;
            end else begin
               col_cnt_ff <= col_cnt_ff + PCOL_W'(1);
            end
         end
         if (cmd.nxt_load) begin
            if (nxt_is_row_ff) nxt_row_ff <= div_quot[PROW_W-1:0];
            else nxt_col_ff <= div_quot[POS_W-1:0];
         end
         if (cmd.advance) begin
            if ((DIM_W'(src_col_ff) + DIM_W'(1)) >= w) begin
               src_col_ff <= '0;
               if ((DIM_W'(src_row_ff) + DIM_W'(1)) >= h) src_row_ff <= '0;
               else src_row_ff <= src_row_ff + POS_W'(1);
            end else begin
               src_col_ff <= src_col_ff + POS_W'(1);
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.latch_item) v_ff <= cfg.wide_samples ? req_sample
                                                    : {8'd0, req_sample[PIX_W-1:0]};
      if (cmd.pix_direct) pix_ff <= pix_direct;
      if (cmd.pix_load) pix_ff <= div_quot[PIX_W-1:0];
      if (cmd.emit) begin
         out_pix_ff       <= pix_ff;
         out_col_ff       <= col_cnt_ff;
         out_row_ff       <= row_cnt_ff[POS_W-1:0];
         out_row_end_ff   <= row_end_now;
         out_frame_end_ff <= frame_end_now;
         nxt_is_row_ff    <= row_end_now;
      end
   end

   assign rsp_tvalid    = out_valid_ff;
   assign rsp_pixel     = out_pix_ff;
   assign rsp_column    = out_col_ff;
   assign rsp_row       = out_row_ff;
   assign rsp_row_end   = out_row_end_ff;
   assign rsp_frame_end = out_frame_end_ff;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("result loaded over an untaken one");

   a_ph_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.ph_load |=> ph_ff != '0)
      else $error("preview height zero");

   a_min_max: assert property (@(posedge clock) disable iff (reset)
      cmd.stats_update |=> min_ff <= max_ff)
      else $error("statistics min above max");

endmodule
